// ----- rtl/core/rlpl_pkg.sv -----
package rlpl_pkg;

    localparam int ROUTES = 16;
    localparam int SLOT_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CNT_W  = $clog2(ROUTES + 1);

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOROUTE = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_count;

    typedef struct packed {
        logic        mode;
        logic [31:0] address;
        logic [31:0] new_subnet;
        logic [31:0] new_mask;
        logic [5:0]  new_prefix;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] route_slot;
        logic [5:0] route_prefix;
    } t_out;

    typedef struct packed {
        logic [31:0] subnet;
        logic [31:0] mask;
        logic [5:0]  prefix;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic hit;
        logic take;
    } t_match;

    // slot number as carried on the result: low four bits only
    function automatic logic [3:0] slot_out(input t_slot s);
        logic [31:0] w;
        w = 32'(s);
        return w[3:0];
    endfunction

endpackage

// ----- rtl/core/route_longest_prefix_lookup_unit.sv -----
// an add writes its result register on transfer in, then passes it to the output register
// a lookup reads one stored route per cycle from the table ram, then passes its result
// to the output register through the done state; on an empty table the scan ends at once
// one item at a time: o_ready returns in the same cycle that the result enters the output
// register; a held result stalls this
// reset clears the fill count and all control state; table contents are not cleared
module route_longest_prefix_lookup_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rlpl_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rlpl_pkg::t_out o_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    rlpl_pkg::t_count r_fill, n_fill;
    rlpl_pkg::t_count r_rd_idx, n_rd_idx;
    logic r_pend, n_pend;
    logic r_found, n_found;
    logic r_out_valid, n_out_valid;

    rlpl_pkg::t_slot r_pend_idx, n_pend_idx;
    rlpl_pkg::t_slot r_best_slot, n_best_slot;
    logic [5:0] r_best_prefix, n_best_prefix;
    logic [31:0] r_addr, n_addr;
    rlpl_pkg::t_out r_res, n_res;
    rlpl_pkg::t_out r_out, n_out;

    logic in_xfer;
    logic is_full;
    logic ram_we;
    rlpl_pkg::t_entry wr_entry;
    rlpl_pkg::t_entry rd_entry;
    logic [rlpl_pkg::ENTRY_W-1:0] rd_raw;
    rlpl_pkg::t_match match;

    assign o_ready = (r_state == S_IDLE);
    assign in_xfer = i_valid && o_ready;
    assign is_full = (r_fill == rlpl_pkg::t_count'(rlpl_pkg::ROUTES));
    assign ram_we  = in_xfer && (i_data.mode == rlpl_pkg::MODE_ADD) && !is_full;

    assign wr_entry.subnet = i_data.new_subnet;
    assign wr_entry.mask   = i_data.new_mask;
    assign wr_entry.prefix = i_data.new_prefix;

    rlpl_ram #(
        .WIDTH(rlpl_pkg::ENTRY_W),
        .DEPTH(rlpl_pkg::ROUTES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_fill[rlpl_pkg::SLOT_W-1:0]),
        .i_wdata(wr_entry),
        .i_raddr(r_rd_idx[rlpl_pkg::SLOT_W-1:0]),
        .o_rdata(rd_raw)
    );

    assign rd_entry = rd_raw;

    rlpl_match u_match (
        .i_entry      (rd_entry),
        .i_address    (r_addr),
        .i_found      (r_found),
        .i_best_prefix(r_best_prefix),
        .o_match      (match)
    );

    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_rd_idx      = r_rd_idx;
        n_pend        = r_pend;
        n_found       = r_found;
        n_out_valid   = r_out_valid;
        n_pend_idx    = r_pend_idx;
        n_best_slot   = r_best_slot;
        n_best_prefix = r_best_prefix;
        n_addr        = r_addr;
        n_res         = r_res;
        n_out         = r_out;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_data.mode == rlpl_pkg::MODE_ADD) begin
                        n_res.route_prefix = 6'd0;
                        if (is_full) begin
                            n_res.status     = rlpl_pkg::ST_FULL;
                            n_res.route_slot = 4'd0;
                        end else begin
                            n_res.status     = rlpl_pkg::ST_OK;
                            n_res.route_slot = rlpl_pkg::slot_out(r_fill[rlpl_pkg::SLOT_W-1:0]);
                            n_fill           = r_fill + rlpl_pkg::t_count'(1);
                        end
                        n_state = S_DONE;
                    end else begin
                        n_addr        = i_data.address;
                        n_rd_idx      = '0;
                        n_pend        = 1'b0;
                        n_found       = 1'b0;
                        n_best_slot   = '0;
                        n_best_prefix = 6'd0;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // ram data for r_pend_idx is valid this cycle
                if (r_pend && match.take) begin
                    n_found       = 1'b1;
                    n_best_slot   = r_pend_idx;
                    n_best_prefix = rd_entry.prefix;
                end
                if (r_rd_idx != r_fill) begin
                    n_rd_idx   = r_rd_idx + rlpl_pkg::t_count'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[rlpl_pkg::SLOT_W-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (r_found) begin
                            n_res.status       = rlpl_pkg::ST_OK;
                            n_res.route_slot   = rlpl_pkg::slot_out(r_best_slot);
                            n_res.route_prefix = r_best_prefix;
                        end else begin
                            n_res.status       = rlpl_pkg::ST_NOROUTE;
                            n_res.route_slot   = 4'd0;
                            n_res.route_prefix = 6'd0;
                        end
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx    <= n_pend_idx;
        r_best_slot   <= n_best_slot;
        r_best_prefix <= n_best_prefix;
        r_addr        <= n_addr;
        r_res         <= n_res;
        r_out         <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ----- rtl/core/rlpl_ram.sv -----
module rlpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/rlpl_match.sv -----
module rlpl_match (
    input  rlpl_pkg::t_entry i_entry,
    input  logic [31:0]      i_address,
    input  logic             i_found,
    input  logic [5:0]       i_best_prefix,
    output rlpl_pkg::t_match o_match
);

    logic hit;

    // prefix zero is a default route and matches anything
    assign hit = (i_entry.prefix == 6'd0) || ((i_address & i_entry.mask) == i_entry.subnet);

    // strict greater keeps the earliest slot on a tie
    assign o_match.hit  = hit;
    assign o_match.take = hit && (!i_found || (i_entry.prefix > i_best_prefix));

endmodule
